// ===== design/lkvc_pkg.sv =====
// shared types and constants for the lru key/value cache
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 64;
  localparam int CFG_W      = 5;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CAP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef struct packed {
    logic                  mode;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] store_value;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
  } out_item_t;

  typedef logic [ENTRIES-1:0][KEY_BITS-1:0]   key_arr_t;
  typedef logic [ENTRIES-1:0][VALUE_BITS-1:0] data_arr_t;
  typedef logic [ENTRIES-1:0][RANK_W-1:0]     rank_arr_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TOUCH,
    OP_INSERT
  } op_t;

  // table update for one transfer
  typedef struct packed {
    op_t                   op;
    logic                  data_we;
    logic                  evict;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W-1:0]      victim;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] data;
  } upd_t;

endpackage

// ===== design/lkvc_decide.sv =====
// key match, victim and free slot search, result and table update decision
`timescale 1ns / 1ps

module lkvc_decide (
  input  logic                       go,
  input  lkvc_pkg::in_item_t         item,
  input  logic [lkvc_pkg::CFG_W-1:0] capacity,
  input  logic [lkvc_pkg::ENTRIES-1:0] valid,
  input  lkvc_pkg::key_arr_t         keys,
  input  lkvc_pkg::data_arr_t        data,
  input  lkvc_pkg::rank_arr_t        ranks,
  input  logic [lkvc_pkg::CNT_W-1:0] occ,
  output lkvc_pkg::out_item_t        result,
  output lkvc_pkg::upd_t             upd
);
  import lkvc_pkg::*;

  // lowest set bit wins
  function automatic logic [IDX_W-1:0] first_one(input logic [ENTRIES-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim_vec;
  logic [ENTRIES-1:0] victim_oh;
  logic [ENTRIES-1:0] free_vec;
  logic               found;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   victim_idx;
  logic [IDX_W-1:0]   slot_idx;
  logic [CAP_W-1:0]   cap_wide;
  logic [CNT_W-1:0]   cap_eff;
  logic [CNT_W-1:0]   occ_m1;
  logic               evict;

  // parallel key compare and oldest-entry compare
  always_comb begin
    occ_m1 = occ - CNT_W'(1);
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]      = valid[i] && (keys[i] == item.lookup_key);
      victim_vec[i] = valid[i] && (ranks[i] == occ_m1[RANK_W-1:0]);
    end
  end

  assign found      = |match;
  assign hit_idx    = first_one(match);
  assign victim_idx = first_one(victim_vec);

  // capacity clamp: zero acts as one, large values saturate
  always_comb begin
    cap_wide = CAP_W'(capacity);
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_wide > CAP_W'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = cap_wide[CNT_W-1:0];
    end
  end

  // store of a new key into a full cache drops the oldest entry first
  assign evict     = item.mode && !found && (occ >= cap_eff);
  assign victim_oh = evict ? (ENTRIES'(1) << victim_idx) : '0;
  assign free_vec  = ~(valid & ~victim_oh);
  assign slot_idx  = first_one(free_vec);

  // result item
  always_comb begin
    result.hit        = found;
    result.read_value = (!item.mode && found) ? data[hit_idx] : '0;
    result.evicted    = evict;
  end

  // table update
  always_comb begin
    upd.op      = OP_NONE;
    upd.data_we = 1'b0;
    upd.evict   = 1'b0;
    upd.idx     = hit_idx;
    upd.victim  = victim_idx;
    upd.key     = item.lookup_key;
    upd.data    = item.store_value;
    if (go) begin
      if (found) begin
        upd.op      = OP_TOUCH;
        upd.data_we = item.mode;
      end else if (item.mode) begin
        upd.op      = OP_INSERT;
        upd.data_we = 1'b1;
        upd.evict   = evict;
        upd.idx     = slot_idx;
      end
    end
  end

endmodule

// ===== design/lkvc_entries.sv =====
// entry table: valid bits, keys, values, recency ranks and occupancy
`timescale 1ns / 1ps

module lkvc_entries (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lkvc_pkg::upd_t               upd,
  output logic [lkvc_pkg::ENTRIES-1:0] valid_r,
  output lkvc_pkg::key_arr_t           key_r,
  output lkvc_pkg::data_arr_t          data_r,
  output lkvc_pkg::rank_arr_t          rank_r,
  output logic [lkvc_pkg::CNT_W-1:0]   occ_r
);
  import lkvc_pkg::*;

  logic [ENTRIES-1:0] valid_nxt;
  rank_arr_t          rank_nxt;
  logic [CNT_W-1:0]   occ_nxt;
  logic [ENTRIES-1:0] victim_oh;
  logic [ENTRIES-1:0] kept;
  logic [RANK_W-1:0]  touch_rank;

  assign victim_oh  = upd.evict ? (ENTRIES'(1) << upd.victim) : '0;
  assign kept       = valid_r & ~victim_oh;
  assign touch_rank = rank_r[upd.idx];

  // rank ageing, valid and occupancy update
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    occ_nxt   = occ_r;
    case (upd.op)
      OP_TOUCH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (rank_r[i] < touch_rank)) rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
        rank_nxt[upd.idx] = '0;
      end
      OP_INSERT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (kept[i]) rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
        valid_nxt          = kept;
        valid_nxt[upd.idx] = 1'b1;
        rank_nxt[upd.idx]  = '0;
        occ_nxt            = upd.evict ? occ_r : occ_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rank_r  <= '0;
      occ_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // key and value storage
  always_ff @(posedge clk) begin
    if (upd.op == OP_INSERT) key_r[upd.idx] <= upd.key;
    if (upd.data_we) data_r[upd.idx] <= upd.data;
  end

endmodule

// ===== design/lru_key_value_cache_core.sv =====
// top level of the fully associative lru key/value cache
//
//   channel   ports                        payload
//   in        in_valid / in_ready          in_item   (lkvc_pkg::in_item_t)
//   out       out_valid / out_ready        out_item  (lkvc_pkg::out_item_t)
//   cfg       cfg_valid / cfg_ready        cfg_data  (capacity in use)
//
// one item per cycle sustained while out_ready stays high; items pass the input register, then the result register
// the rate is set by the combinational key match and the rank update across all entries
// synchronous reset clears valid bits, ranks and occupancy; capacity returns to 16
// a stalled result holds in the result register while the input register may still fill
// cfg_ready is always high
`timescale 1ns / 1ps

module lru_key_value_cache_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lkvc_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lkvc_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkvc_pkg::CFG_W-1:0] cfg_data
);
  import lkvc_pkg::*;

  in_item_t           in_item_r;
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  out_item_t          out_item_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [CFG_W-1:0]   cap_r;
  logic               in_xfer;
  logic               adv;
  out_item_t          result;
  upd_t               upd;
  logic [ENTRIES-1:0] valid_w;
  key_arr_t           key_w;
  data_arr_t          data_w;
  rank_arr_t          rank_w;
  logic [CNT_W-1:0]   occ_w;

  // handshake control
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    s1_valid_nxt = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) in_item_r <= in_item;
    if (adv) out_item_r <= result;
  end

  lkvc_decide u_decide (
    .go       (adv),
    .item     (in_item_r),
    .capacity (cap_r),
    .valid    (valid_w),
    .keys     (key_w),
    .data     (data_w),
    .ranks    (rank_w),
    .occ      (occ_w),
    .result   (result),
    .upd      (upd)
  );

  lkvc_entries u_entries (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .valid_r (valid_w),
    .key_r   (key_w),
    .data_r  (data_w),
    .rank_r  (rank_w),
    .occ_r   (occ_w)
  );

`ifndef SYNTH
  // occupancy tracks the number of valid entries
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_w) == int'(occ_w))
    else $error("occupancy does not match valid entries");

  // occupancy never exceeds the table size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_w <= CNT_W'(ENTRIES))
    else $error("occupancy above table size");

  // an insert with eviction leaves occupancy unchanged
  a_evict_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.op == OP_INSERT && upd.evict) |=> (occ_w == $past(occ_w)))
    else $error("eviction changed occupancy");

  // an inserted slot is valid afterwards
  a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.op == OP_INSERT) |=> valid_w[$past(upd.idx)])
    else $error("inserted slot not valid");
`endif

endmodule
